// ===== sv/bcds_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, sequencer codes and types for the bound-charge stencil.
// Used by every module of the block; depends on nothing.
package bcds_pkg;

    localparam int NX_MAX        = 64;
    localparam int NY_MAX        = 64;
    localparam int NUM_MATERIALS = 16;
    localparam int FIRST_EMIT    = 2;

    localparam int X_AW     = $clog2(NX_MAX);
    localparam int Y_AW     = $clog2(NY_MAX);
    localparam int PLANE_AW = X_AW + Y_AW;
    localparam int MAT_W    = 4;
    localparam int XW       = 7;
    localparam int YW       = 7;
    localparam int ZW       = 13;
    localparam int DW       = 32;
    localparam int ACC_W    = 50;
    localparam int ST_W     = 4;

    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_WX   = 4'd1;
    localparam logic [ST_W-1:0] ST_WY   = 4'd2;
    localparam logic [ST_W-1:0] ST_WZ   = 4'd3;
    localparam logic [ST_W-1:0] ST_TX   = 4'd4;
    localparam logic [ST_W-1:0] ST_TY   = 4'd5;
    localparam logic [ST_W-1:0] ST_TZ   = 4'd6;
    localparam logic [ST_W-1:0] ST_SUM  = 4'd7;
    localparam logic [ST_W-1:0] ST_OUT  = 4'd8;

    localparam logic [2:0] CFG_NX = 3'd0;
    localparam logic [2:0] CFG_NY = 3'd1;
    localparam logic [2:0] CFG_NZ = 3'd2;
    localparam logic [2:0] CFG_PX = 3'd3;
    localparam logic [2:0] CFG_PY = 3'd4;
    localparam logic [2:0] CFG_PZ = 3'd5;

    typedef struct packed {
        logic signed [DW-1:0] eps_x;
        logic signed [DW-1:0] eps_y;
        logic signed [DW-1:0] eps_z;
        logic                 nonc;
    } t_mat_rd;

    typedef struct packed {
        logic signed [DW-1:0] old_x;
        logic signed [DW-1:0] old_y;
        logic signed [DW-1:0] old_z;
    } t_buf_rd;

    typedef struct packed {
        logic signed [DW-1:0] wx;
        logic signed [DW-1:0] wy;
        logic signed [DW-1:0] wz;
    } t_wvals;

    typedef struct packed {
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        logic signed [DW-1:0] pz;
    } t_scales;

    function automatic logic signed [DW-1:0] f_sat32(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/bcds_mat_table.sv =====
`timescale 1ns / 1ps
// Material table: permittivity per axis and nonconductive flag, 16 entries.
// Written on load transfers, read through a registered output; uses bcds_pkg.
module bcds_mat_table (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [bcds_pkg::MAT_W-1:0]          i_wr_idx,
    input  logic signed [bcds_pkg::DW-1:0]      i_wr_eps_x,
    input  logic signed [bcds_pkg::DW-1:0]      i_wr_eps_y,
    input  logic signed [bcds_pkg::DW-1:0]      i_wr_eps_z,
    input  logic                                i_wr_nonc,
    input  logic                                i_rd_en,
    input  logic [bcds_pkg::MAT_W-1:0]          i_idx_x,
    input  logic [bcds_pkg::MAT_W-1:0]          i_idx_y,
    input  logic [bcds_pkg::MAT_W-1:0]          i_idx_z,
    input  logic [bcds_pkg::MAT_W-1:0]          i_idx_node,
    output bcds_pkg::t_mat_rd                   o_rd
);

    logic signed [bcds_pkg::DW-1:0] mem_eps_x [bcds_pkg::NUM_MATERIALS];
    logic signed [bcds_pkg::DW-1:0] mem_eps_y [bcds_pkg::NUM_MATERIALS];
    logic signed [bcds_pkg::DW-1:0] mem_eps_z [bcds_pkg::NUM_MATERIALS];
    logic                           mem_nonc  [bcds_pkg::NUM_MATERIALS];

    bcds_pkg::t_mat_rd r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_eps_x[i_wr_idx] <= i_wr_eps_x;
            mem_eps_y[i_wr_idx] <= i_wr_eps_y;
            mem_eps_z[i_wr_idx] <= i_wr_eps_z;
            mem_nonc[i_wr_idx]  <= i_wr_nonc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.eps_x <= mem_eps_x[i_idx_x];
            r_rd.eps_y <= mem_eps_y[i_idx_y];
            r_rd.eps_z <= mem_eps_z[i_idx_z];
            r_rd.nonc  <= mem_nonc[i_idx_node];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== sv/bcds_field_buf.sv =====
`timescale 1ns / 1ps
// Neighbor storage: previous-voxel x weight, row buffer of y weights and
// plane buffer of z weights. Read at transfer, written back by sequencer step.
module bcds_field_buf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [bcds_pkg::X_AW-1:0]           i_xi,
    input  logic [bcds_pkg::Y_AW-1:0]           i_yi,
    input  logic [bcds_pkg::ST_W-1:0]           i_state,
    input  bcds_pkg::t_wvals                    i_w,
    output bcds_pkg::t_buf_rd                   o_rd
);

    logic signed [bcds_pkg::DW-1:0] mem_row   [bcds_pkg::NX_MAX];
    logic signed [bcds_pkg::DW-1:0] mem_plane [bcds_pkg::NX_MAX * bcds_pkg::NY_MAX];

    logic signed [bcds_pkg::DW-1:0]     r_prev_x;
    logic signed [bcds_pkg::DW-1:0]     r_old_y;
    logic signed [bcds_pkg::DW-1:0]     r_old_z;
    logic [bcds_pkg::X_AW-1:0]          r_xi;
    logic [bcds_pkg::PLANE_AW-1:0]      r_paddr;
    logic [bcds_pkg::PLANE_AW-1:0]      paddr;

    assign paddr = {i_yi, i_xi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
        end else if (i_state == bcds_pkg::ST_WZ) begin
            r_prev_x <= i_w.wx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_old_y <= mem_row[i_xi];
            r_old_z <= mem_plane[paddr];
            r_xi    <= i_xi;
            r_paddr <= paddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_state == bcds_pkg::ST_TX) begin
            mem_row[r_xi] <= i_w.wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_state == bcds_pkg::ST_TY) begin
            mem_plane[r_paddr] <= i_w.wz;
        end
    end

    assign o_rd.old_x = r_prev_x;
    assign o_rd.old_y = r_old_y;
    assign o_rd.old_z = r_old_z;

endmodule

// ===== sv/bcds_datapath.sv =====
`timescale 1ns / 1ps
// Arithmetic of one voxel on a single shared 32x32 multiplier, one use per
// sequencer step: weights, saturated differences, scaled sum. Uses bcds_pkg.
module bcds_datapath (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic signed [bcds_pkg::DW-1:0]      i_comp_x,
    input  logic signed [bcds_pkg::DW-1:0]      i_comp_y,
    input  logic signed [bcds_pkg::DW-1:0]      i_comp_z,
    input  logic signed [bcds_pkg::DW-1:0]      i_free_charge,
    input  logic [bcds_pkg::ST_W-1:0]           i_state,
    input  bcds_pkg::t_mat_rd                   i_mat,
    input  bcds_pkg::t_buf_rd                   i_old,
    input  bcds_pkg::t_scales                   i_scale,
    output bcds_pkg::t_wvals                    o_w,
    output logic signed [bcds_pkg::DW-1:0]      o_result
);

    logic signed [bcds_pkg::DW-1:0]    r_ex, r_ey, r_ez, r_rhof;
    logic signed [bcds_pkg::DW-1:0]    r_wx, r_wy, r_wz;
    logic signed [bcds_pkg::DW-1:0]    r_dx, r_dy, r_dz;
    logic signed [63:0]                r_prod;
    logic signed [bcds_pkg::ACC_W-1:0] r_acc;

    logic signed [bcds_pkg::DW-1:0]    op_a, op_b;
    logic signed [63:0]                prod_fl;
    logic signed [bcds_pkg::DW-1:0]    w_sat;
    logic signed [bcds_pkg::ACC_W-1:0] term;

    assign prod_fl = {{16{r_prod[63]}}, r_prod[63:16]};
    assign w_sat   = bcds_pkg::f_sat32(prod_fl);
    assign term    = prod_fl[bcds_pkg::ACC_W-1:0];

    function automatic logic signed [bcds_pkg::DW-1:0] f_diff(
        input logic signed [bcds_pkg::DW-1:0] a,
        input logic signed [bcds_pkg::DW-1:0] b
    );
        logic signed [63:0] d;
        d = {{32{a[31]}}, a} - {{32{b[31]}}, b};
        return bcds_pkg::f_sat32(d);
    endfunction

    always_comb begin
        unique case (i_state)
            bcds_pkg::ST_WX: begin
                op_a = i_mat.eps_x;
                op_b = r_ex;
            end
            bcds_pkg::ST_WY: begin
                op_a = i_mat.eps_y;
                op_b = r_ey;
            end
            bcds_pkg::ST_WZ: begin
                op_a = i_mat.eps_z;
                op_b = r_ez;
            end
            bcds_pkg::ST_TX: begin
                op_a = i_scale.px;
                op_b = r_dx;
            end
            bcds_pkg::ST_TY: begin
                op_a = i_scale.py;
                op_b = r_dy;
            end
            bcds_pkg::ST_TZ: begin
                op_a = i_scale.pz;
                op_b = r_dz;
            end
            default: begin
                op_a = i_scale.pz;
                op_b = r_dz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ex   <= i_comp_x;
            r_ey   <= i_comp_y;
            r_ez   <= i_comp_z;
            r_rhof <= i_free_charge;
        end
        r_prod <= op_a * op_b;
        unique case (i_state)
            bcds_pkg::ST_WY: begin
                r_wx <= w_sat;
            end
            bcds_pkg::ST_WZ: begin
                r_wy <= w_sat;
                r_dx <= f_diff(r_wx, i_old.old_x);
            end
            bcds_pkg::ST_TX: begin
                r_wz <= w_sat;
                r_dy <= f_diff(r_wy, i_old.old_y);
            end
            bcds_pkg::ST_TY: begin
                r_dz  <= f_diff(r_wz, i_old.old_z);
                r_acc <= term - {{(bcds_pkg::ACC_W-bcds_pkg::DW){r_rhof[31]}}, r_rhof};
            end
            bcds_pkg::ST_TZ, bcds_pkg::ST_SUM: begin
                r_acc <= r_acc + term;
            end
            default: begin
            end
        endcase
    end

    assign o_w.wx = r_wx;
    assign o_w.wy = r_wy;
    assign o_w.wz = r_wz;

    assign o_result = i_mat.nonc
        ? bcds_pkg::f_sat32({{(64-bcds_pkg::ACC_W){r_acc[bcds_pkg::ACC_W-1]}}, r_acc})
        : '0;

endmodule

// ===== sv/bound_charge_divergence_stencil.sv =====
`timescale 1ns / 1ps
// Top level of the bound-charge divergence stencil: stream ports, register
// port, position counters and step sequencer; uses bcds_pkg and all submodules.
//
// A load transfer (tuser 0) writes one material entry. A voxel transfer
// (tuser 1) runs from one input transfer to the next through the transfer
// cycle, which also issues the material, row and plane buffer reads, then six
// steps sharing one 32x32 multiplier (three permittivity weights, three scaled
// differences) and two accumulate and output steps; the output step holds while
// a result voxel finds the output register still full. Voxels with x, y and z
// all at least 2 give one result; the output register lets the next voxel start
// while a result waits. Material entries must be loaded before any voxel uses
// them; the neighbor buffers need no clearing after reset.
module bound_charge_divergence_stencil (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // load_index[3:0], comp_x[35:4], comp_y[67:36], comp_z[99:68],
    // free_charge[131:100], nonconductive_flag[132], mat_x[136:133],
    // mat_y[140:137], mat_z[144:141], mat_node[148:145], zero[151:149]
    input  logic [151:0]  s_axis_tdata,
    // cmd[0]
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // bound_charge[31:0], out_x[38:32], out_y[45:39], out_z[58:46], zero[63:59]
    output logic [63:0]   m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    localparam logic [bcds_pkg::XW-1:0] NX_LIM = bcds_pkg::XW'(bcds_pkg::NX_MAX);
    localparam logic [bcds_pkg::YW-1:0] NY_LIM = bcds_pkg::YW'(bcds_pkg::NY_MAX);
    localparam logic [bcds_pkg::XW-1:0] X_EMIT = bcds_pkg::XW'(bcds_pkg::FIRST_EMIT);
    localparam logic [bcds_pkg::YW-1:0] Y_EMIT = bcds_pkg::YW'(bcds_pkg::FIRST_EMIT);
    localparam logic [bcds_pkg::ZW-1:0] Z_EMIT = bcds_pkg::ZW'(bcds_pkg::FIRST_EMIT);

    logic [bcds_pkg::XW-1:0] r_grid_nx;
    logic [bcds_pkg::YW-1:0] r_grid_ny;
    logic [bcds_pkg::ZW-1:0] r_grid_nz;
    bcds_pkg::t_scales       r_scale;

    logic [bcds_pkg::ST_W-1:0] r_state, n_state;
    logic [bcds_pkg::XW-1:0]   r_pos_x, n_pos_x;
    logic [bcds_pkg::YW-1:0]   r_pos_y, n_pos_y;
    logic [bcds_pkg::ZW-1:0]   r_pos_z, n_pos_z;
    logic                      r_emit, r_last;
    logic [bcds_pkg::XW-1:0]   r_cx;
    logic [bcds_pkg::YW-1:0]   r_cy;
    logic [bcds_pkg::ZW-1:0]   r_cz;

    logic                      r_m_valid;
    logic [63:0]               r_m_data;
    logic                      r_m_last;

    logic [bcds_pkg::XW-1:0]   nx_eff;
    logic [bcds_pkg::YW-1:0]   ny_eff;
    logic [bcds_pkg::ZW-1:0]   nz_eff;
    logic                      in_xfer, voxel_xfer, load_xfer;
    logic                      end_x, end_y, end_z;
    logic                      out_free, finish;

    logic [bcds_pkg::X_AW-1:0] xi;
    logic [bcds_pkg::Y_AW-1:0] yi;

    bcds_pkg::t_mat_rd mat_rd;
    bcds_pkg::t_buf_rd buf_rd;
    bcds_pkg::t_wvals  wvals;
    logic signed [bcds_pkg::DW-1:0] result;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == bcds_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign voxel_xfer    = in_xfer && s_axis_tuser[0];
    assign load_xfer     = in_xfer && !s_axis_tuser[0];

    assign nx_eff = (r_grid_nx == '0) ? bcds_pkg::XW'(1)
                  : (r_grid_nx > NX_LIM) ? NX_LIM : r_grid_nx;
    assign ny_eff = (r_grid_ny == '0) ? bcds_pkg::YW'(1)
                  : (r_grid_ny > NY_LIM) ? NY_LIM : r_grid_ny;
    assign nz_eff = (r_grid_nz == '0) ? bcds_pkg::ZW'(1) : r_grid_nz;

    assign end_x = (r_pos_x >= nx_eff);
    assign end_y = (r_pos_y >= ny_eff);
    assign end_z = (r_pos_z >= nz_eff);

    assign xi = bcds_pkg::X_AW'(r_pos_x - bcds_pkg::XW'(1));
    assign yi = bcds_pkg::Y_AW'(r_pos_y - bcds_pkg::YW'(1));

    assign out_free = !r_m_valid || m_axis_tready;
    assign finish   = (r_state == bcds_pkg::ST_OUT) && (!r_emit || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_nx <= bcds_pkg::XW'(1);
            r_grid_ny <= bcds_pkg::YW'(1);
            r_grid_nz <= bcds_pkg::ZW'(1);
            r_scale   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bcds_pkg::CFG_NX: r_grid_nx  <= i_cfg_data[bcds_pkg::XW-1:0];
                bcds_pkg::CFG_NY: r_grid_ny  <= i_cfg_data[bcds_pkg::YW-1:0];
                bcds_pkg::CFG_NZ: r_grid_nz  <= i_cfg_data[bcds_pkg::ZW-1:0];
                bcds_pkg::CFG_PX: r_scale.px <= i_cfg_data;
                bcds_pkg::CFG_PY: r_scale.py <= i_cfg_data;
                bcds_pkg::CFG_PZ: r_scale.pz <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        if (voxel_xfer) begin
            if (end_x) begin
                n_pos_x = bcds_pkg::XW'(1);
                if (end_y) begin
                    n_pos_y = bcds_pkg::YW'(1);
                    n_pos_z = end_z ? bcds_pkg::ZW'(1) : r_pos_z + bcds_pkg::ZW'(1);
                end else begin
                    n_pos_y = r_pos_y + bcds_pkg::YW'(1);
                end
            end else begin
                n_pos_x = r_pos_x + bcds_pkg::XW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcds_pkg::ST_IDLE: if (voxel_xfer) n_state = bcds_pkg::ST_WX;
            bcds_pkg::ST_WX:   n_state = bcds_pkg::ST_WY;
            bcds_pkg::ST_WY:   n_state = bcds_pkg::ST_WZ;
            bcds_pkg::ST_WZ:   n_state = bcds_pkg::ST_TX;
            bcds_pkg::ST_TX:   n_state = bcds_pkg::ST_TY;
            bcds_pkg::ST_TY:   n_state = bcds_pkg::ST_TZ;
            bcds_pkg::ST_TZ:   n_state = bcds_pkg::ST_SUM;
            bcds_pkg::ST_SUM:  n_state = bcds_pkg::ST_OUT;
            bcds_pkg::ST_OUT:  if (finish) n_state = bcds_pkg::ST_IDLE;
            default:           n_state = bcds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcds_pkg::ST_IDLE;
            r_pos_x <= bcds_pkg::XW'(1);
            r_pos_y <= bcds_pkg::YW'(1);
            r_pos_z <= bcds_pkg::ZW'(1);
        end else begin
            r_state <= n_state;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (voxel_xfer) begin
            r_cx   <= r_pos_x;
            r_cy   <= r_pos_y;
            r_cz   <= r_pos_z;
            r_emit <= (r_pos_x >= X_EMIT) && (r_pos_y >= Y_EMIT) && (r_pos_z >= Z_EMIT);
            r_last <= end_x && end_y && end_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (finish && r_emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish && r_emit) begin
            r_m_data <= {5'b0, r_cz, r_cy, r_cx, result};
            r_m_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    bcds_mat_table u_mat (
        .i_clk      (i_clk),
        .i_wr_en    (load_xfer),
        .i_wr_idx   (s_axis_tdata[3:0]),
        .i_wr_eps_x (s_axis_tdata[35:4]),
        .i_wr_eps_y (s_axis_tdata[67:36]),
        .i_wr_eps_z (s_axis_tdata[99:68]),
        .i_wr_nonc  (s_axis_tdata[132]),
        .i_rd_en    (voxel_xfer),
        .i_idx_x    (s_axis_tdata[136:133]),
        .i_idx_y    (s_axis_tdata[140:137]),
        .i_idx_z    (s_axis_tdata[144:141]),
        .i_idx_node (s_axis_tdata[148:145]),
        .o_rd       (mat_rd)
    );

    bcds_field_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (voxel_xfer),
        .i_xi    (xi),
        .i_yi    (yi),
        .i_state (r_state),
        .i_w     (wvals),
        .o_rd    (buf_rd)
    );

    bcds_datapath u_dp (
        .i_clk         (i_clk),
        .i_load        (voxel_xfer),
        .i_comp_x      (s_axis_tdata[35:4]),
        .i_comp_y      (s_axis_tdata[67:36]),
        .i_comp_z      (s_axis_tdata[99:68]),
        .i_free_charge (s_axis_tdata[131:100]),
        .i_state       (r_state),
        .i_mat         (mat_rd),
        .i_old         (buf_rd),
        .i_scale       (r_scale),
        .o_w           (wvals),
        .o_result      (result)
    );

endmodule
